/* hdl/dual_servo_jog_with_release_timeout_assert.svh */
// ============================================================================
// Assertion macros for the dual servo jog controller
// Shorthands for clocked assertions that are disabled while aresetn is low.
// ============================================================================
`ifndef DUAL_SERVO_JOG_WITH_RELEASE_TIMEOUT_ASSERT_SVH
`define DUAL_SERVO_JOG_WITH_RELEASE_TIMEOUT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSJ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSJ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/dsj_pkg.sv */
// ============================================================================
// dsj_pkg
// Shared widths, constants, key codes and state types of the servo jog block.
// ============================================================================
package dsj_pkg;

    localparam int PULSE_W   = 11;
    localparam int ELAPSED_W = 9;
    localparam int CFG_W     = 9;
    localparam int CFG_ADDR_W = 2;
    localparam int KEY_W     = 8;
    localparam int RESULT_W  = 48;

    localparam logic [PULSE_W-1:0] NEUTRAL_PULSE = 11'd1500;
    localparam logic [PULSE_W-1:0] CCW_MIN    = 11'd1000;
    localparam logic [PULSE_W-1:0] CCW_MAX    = 11'd1350;
    localparam logic [PULSE_W-1:0] CW_MIN     = 11'd1650;
    localparam logic [PULSE_W-1:0] CW_MAX     = 11'd2000;
    localparam logic [PULSE_W-1:0] CCW_RESET  = 11'd1300;
    localparam logic [PULSE_W-1:0] CW_RESET   = 11'd1700;
    localparam logic [PULSE_W:0]   SPEED_STEP = 12'd100;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 9'd511;

    localparam logic [CFG_W-1:0] FIRST_PRESS_RESET = 9'd260;
    localparam logic [CFG_W-1:0] HOLD_RESET        = 9'd100;
    localparam logic [CFG_W-1:0] SETTLE_RESET      = 9'd50;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_PRESS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD        = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SETTLE      = 2'd2;

    // Command bytes, lower and upper case.
    localparam logic [KEY_W-1:0] KEY_Q_LO = 8'h71;
    localparam logic [KEY_W-1:0] KEY_Q_UP = 8'h51;
    localparam logic [KEY_W-1:0] KEY_E_LO = 8'h65;
    localparam logic [KEY_W-1:0] KEY_E_UP = 8'h45;
    localparam logic [KEY_W-1:0] KEY_A_LO = 8'h61;
    localparam logic [KEY_W-1:0] KEY_A_UP = 8'h41;
    localparam logic [KEY_W-1:0] KEY_D_LO = 8'h64;
    localparam logic [KEY_W-1:0] KEY_D_UP = 8'h44;
    localparam logic [KEY_W-1:0] KEY_W_LO = 8'h77;
    localparam logic [KEY_W-1:0] KEY_W_UP = 8'h57;
    localparam logic [KEY_W-1:0] KEY_S_LO = 8'h73;
    localparam logic [KEY_W-1:0] KEY_S_UP = 8'h53;

    typedef struct packed {
        logic [PULSE_W-1:0]   pulse;
        logic [ELAPSED_W-1:0] elapsed;
        logic                 moving;
        logic                 first;
    } motor_t;

    typedef struct packed {
        logic [PULSE_W-1:0] ccw;
        logic [PULSE_W-1:0] cw;
        motor_t [1:0]       motor;
    } state_t;

    typedef struct packed {
        logic [CFG_W-1:0] first_press;
        logic [CFG_W-1:0] hold;
        logic [CFG_W-1:0] settle;
    } cfg_t;

endpackage

/* hdl/dsj_core.sv */
// ============================================================================
// dsj_core
// Next-state logic for one word: speed keys, motor drives and timeouts.
// ============================================================================
module dsj_core (
    input  dsj_pkg::state_t                i_state,
    input  logic                           i_tick,
    input  logic [dsj_pkg::KEY_W-1:0]      i_key,
    input  dsj_pkg::cfg_t                  i_cfg,
    output dsj_pkg::state_t                o_state
);

    function automatic logic [dsj_pkg::PULSE_W-1:0] clamp_width(
        input logic [dsj_pkg::PULSE_W:0]   v,
        input logic [dsj_pkg::PULSE_W-1:0] lo,
        input logic [dsj_pkg::PULSE_W-1:0] hi
    );
        logic [dsj_pkg::PULSE_W-1:0] r;
        if (v < {1'b0, lo}) begin
            r = lo;
        end else if (v > {1'b0, hi}) begin
            r = hi;
        end else begin
            r = v[dsj_pkg::PULSE_W-1:0];
        end
        return r;
    endfunction

    // Elapsed count, optional drive, then the timeout check on the result.
    function automatic dsj_pkg::motor_t motor_step(
        input dsj_pkg::motor_t               cur,
        input logic                          tick,
        input logic                          drive,
        input logic [dsj_pkg::PULSE_W-1:0]   pulse,
        input dsj_pkg::cfg_t                 cfg
    );
        dsj_pkg::motor_t               m;
        logic [dsj_pkg::CFG_W-1:0]     limit;
        m = cur;
        if (tick && m.moving && (m.elapsed != dsj_pkg::ELAPSED_MAX)) begin
            m.elapsed = m.elapsed + 9'd1;
        end
        if (drive) begin
            m.pulse   = pulse;
            m.elapsed = '0;
            m.moving  = 1'b1;
        end
        limit = m.first ? cfg.first_press : cfg.hold;
        if (m.moving) begin
            if (m.elapsed > limit) begin
                m.pulse  = dsj_pkg::NEUTRAL_PULSE;
                m.moving = 1'b0;
                m.first  = 1'b1;
            end else if (m.elapsed > cfg.settle) begin
                m.first = 1'b0;
            end
        end
        return m;
    endfunction

    logic [1:0]                  drive;
    logic [dsj_pkg::PULSE_W-1:0] drive_pulse [2];
    logic [dsj_pkg::PULSE_W-1:0] ccw_next;
    logic [dsj_pkg::PULSE_W-1:0] cw_next;

    always_comb begin
        drive          = 2'b00;
        drive_pulse[0] = i_state.ccw;
        drive_pulse[1] = i_state.ccw;
        ccw_next       = i_state.ccw;
        cw_next        = i_state.cw;
        if (!i_tick) begin
            case (i_key)
                dsj_pkg::KEY_Q_LO, dsj_pkg::KEY_Q_UP: begin
                    ccw_next = clamp_width({1'b0, i_state.ccw} + dsj_pkg::SPEED_STEP,
                                           dsj_pkg::CCW_MIN, dsj_pkg::CCW_MAX);
                    cw_next  = clamp_width({1'b0, i_state.cw} - dsj_pkg::SPEED_STEP,
                                           dsj_pkg::CW_MIN, dsj_pkg::CW_MAX);
                end
                dsj_pkg::KEY_E_LO, dsj_pkg::KEY_E_UP: begin
                    ccw_next = clamp_width({1'b0, i_state.ccw} - dsj_pkg::SPEED_STEP,
                                           dsj_pkg::CCW_MIN, dsj_pkg::CCW_MAX);
                    cw_next  = clamp_width({1'b0, i_state.cw} + dsj_pkg::SPEED_STEP,
                                           dsj_pkg::CW_MIN, dsj_pkg::CW_MAX);
                end
                dsj_pkg::KEY_A_LO, dsj_pkg::KEY_A_UP: begin
                    drive[0]       = 1'b1;
                    drive_pulse[0] = i_state.ccw;
                end
                dsj_pkg::KEY_D_LO, dsj_pkg::KEY_D_UP: begin
                    drive[0]       = 1'b1;
                    drive_pulse[0] = i_state.cw;
                end
                dsj_pkg::KEY_W_LO, dsj_pkg::KEY_W_UP: begin
                    drive[1]       = 1'b1;
                    drive_pulse[1] = i_state.ccw;
                end
                dsj_pkg::KEY_S_LO, dsj_pkg::KEY_S_UP: begin
                    drive[1]       = 1'b1;
                    drive_pulse[1] = i_state.cw;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_state.ccw = ccw_next;
        o_state.cw  = cw_next;
        for (int m = 0; m < 2; m++) begin
            o_state.motor[m] = motor_step(i_state.motor[m], i_tick, drive[m],
                                          drive_pulse[m], i_cfg);
        end
    end

endmodule

/* hdl/dual_servo_jog_with_release_timeout.sv */
// ============================================================================
// dual_servo_jog_with_release_timeout
// Keyboard jog controller for two servos with a release timeout per motor.
// ============================================================================
//
// Channel  Direction  Handshake            Contents
// s_       in         s_tvalid / s_tready  s_tuser = tick flag, s_tdata = key byte
// m_       out        m_tvalid / m_tready  m_tdata = pulses, active flags, widths
// cfg_     in         cfg_wr_en            cfg_addr selects a timing register
//
// One word is accepted per clock cycle while s_tready is high. The state is
// updated in the cycle a word is accepted; its result appears on m_tdata in
// the next cycle when the output register is free, else in the skid register.
// The result side has a two-word buffer (output register plus skid
// register); s_tready is a registered signal that falls only once both are
// full, so a stalled consumer stops the input after two words.
// Reset is synchronous and active low: all state and the timing registers
// return to their initial values and the output buffer is emptied.
//
module dual_servo_jog_with_release_timeout (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Bits [7:0]: key byte (only used when s_tuser is low).
    input  logic [dsj_pkg::KEY_W-1:0]         s_tdata,
    // Bit 0: opcode, high for a one-millisecond tick, low for a key byte.
    input  logic                              s_tuser,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // From bit 0: motor_one_pulse [10:0], motor_two_pulse [21:11],
    // motor_one_active [22], motor_two_active [23], ccw_width [34:24],
    // cw_width [45:35], zero padding [47:46].
    output logic [dsj_pkg::RESULT_W-1:0]      m_tdata,

    input  logic                              cfg_wr_en,
    input  logic [dsj_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [dsj_pkg::CFG_W-1:0]         cfg_wdata
);

    // Timing registers; the user must write them only while the block is idle (not enforced here).
    dsj_pkg::cfg_t cfg_reg;

    // Controller state and its next value for the word on the input.
    dsj_pkg::state_t state_reg;
    dsj_pkg::state_t state_next;

    // Two-word result buffer.
    logic                           out_valid_reg;
    logic [dsj_pkg::RESULT_W-1:0]   out_data_reg;
    logic                           skid_valid_reg;
    logic [dsj_pkg::RESULT_W-1:0]   skid_data_reg;

    logic                           in_accept;
    logic                           out_take;
    logic [dsj_pkg::RESULT_W-1:0]   result_word;

    assign in_accept = s_tvalid && s_tready;
    assign out_take  = out_valid_reg && m_tready;

    dsj_core u_core (
        .i_state (state_reg),
        .i_tick  (s_tuser),
        .i_key   (s_tdata),
        .i_cfg   (cfg_reg),
        .o_state (state_next)
    );

    // The result reports the state after the word has been applied.
    assign result_word = {2'b00,
                          state_next.cw,
                          state_next.ccw,
                          state_next.motor[1].moving,
                          state_next.motor[0].moving,
                          state_next.motor[1].pulse,
                          state_next.motor[0].pulse};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_press <= dsj_pkg::FIRST_PRESS_RESET;
            cfg_reg.hold        <= dsj_pkg::HOLD_RESET;
            cfg_reg.settle      <= dsj_pkg::SETTLE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                dsj_pkg::CFG_FIRST_PRESS: cfg_reg.first_press <= cfg_wdata;
                dsj_pkg::CFG_HOLD:        cfg_reg.hold        <= cfg_wdata;
                dsj_pkg::CFG_SETTLE:      cfg_reg.settle      <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.ccw <= dsj_pkg::CCW_RESET;
            state_reg.cw  <= dsj_pkg::CW_RESET;
            for (int m = 0; m < 2; m++) begin
                state_reg.motor[m].pulse   <= dsj_pkg::NEUTRAL_PULSE;
                state_reg.motor[m].elapsed <= '0;
                state_reg.motor[m].moving  <= 1'b0;
                state_reg.motor[m].first   <= 1'b1;
            end
        end else if (in_accept) begin
            state_reg <= state_next;
        end
    end

    // When the output register is taken, the skid word moves up first; a
    // new word can only arrive while the skid register is empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_take) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= in_accept;
                end
            end else if (in_accept) begin
                if (!out_valid_reg) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (in_accept) begin
                out_data_reg <= result_word;
            end
        end else if (in_accept) begin
            if (!out_valid_reg) begin
                out_data_reg <= result_word;
            end else begin
                skid_data_reg <= result_word;
            end
        end
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* hdl/dsj_checker.sv */
// ============================================================================
// dsj_checker
// Port-level assertions for the servo jog controller, bound to the top level.
// ============================================================================
`include "dual_servo_jog_with_release_timeout_assert.svh"

module dsj_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dsj_pkg::RESULT_W-1:0]   m_tdata
);

    logic [dsj_pkg::PULSE_W-1:0] pulse_one;
    logic [dsj_pkg::PULSE_W-1:0] pulse_two;
    logic                        active_one;
    logic                        active_two;
    logic [dsj_pkg::PULSE_W-1:0] ccw_width;
    logic [dsj_pkg::PULSE_W-1:0] cw_width;

    assign pulse_one  = m_tdata[10:0];
    assign pulse_two  = m_tdata[21:11];
    assign active_one = m_tdata[22];
    assign active_two = m_tdata[23];
    assign ccw_width  = m_tdata[34:24];
    assign cw_width   = m_tdata[45:35];

    `DSJ_ASSERT_NOW(a_width_range, m_tvalid,
        (ccw_width >= dsj_pkg::CCW_MIN) && (ccw_width <= dsj_pkg::CCW_MAX) &&
        (cw_width >= dsj_pkg::CW_MIN) && (cw_width <= dsj_pkg::CW_MAX),
        "speed width outside its saturation range")
    `DSJ_ASSERT_NOW(a_stop_one, m_tvalid && !active_one,
        pulse_one == dsj_pkg::NEUTRAL_PULSE, "idle motor one not at stop pulse")
    `DSJ_ASSERT_NOW(a_stop_two, m_tvalid && !active_two,
        pulse_two == dsj_pkg::NEUTRAL_PULSE, "idle motor two not at stop pulse")
    `DSJ_ASSERT_NOW(a_full_buffer, s_tvalid && !s_tready, m_tvalid,
        "input stalled while no result is waiting")
    `DSJ_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "stalled result changed or vanished")

endmodule

bind dual_servo_jog_with_release_timeout dsj_checker u_dsj_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* sim/tb_dual_servo_jog_with_release_timeout.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_dual_servo_jog_with_release_timeout
// Streams key bytes and millisecond ticks into the two-servo jog controller
// and checks every result word against a predicted controller state, under
// several timing register settings and with idling on both stream sides.
// ============================================================================

import dsj_pkg::*;

// Fields of one result word. The first member of a packed struct is the top,
// so this is the port layout read from the top bit down.
typedef struct packed {
    logic [1:0]         pad;
    logic [PULSE_W-1:0] cw_width;
    logic [PULSE_W-1:0] ccw_width;
    logic               motor_two_active;
    logic               motor_one_active;
    logic [PULSE_W-1:0] motor_two_pulse;
    logic [PULSE_W-1:0] motor_one_pulse;
} servo_word_t;

class jog_scoreboard;
    logic [CFG_W-1:0]     first_press_ms;
    logic [CFG_W-1:0]     hold_ms;
    logic [CFG_W-1:0]     settle_ms;
    logic [PULSE_W-1:0]   ccw_us;
    logic [PULSE_W-1:0]   cw_us;
    logic [PULSE_W-1:0]   pulse_us [2];
    logic [ELAPSED_W-1:0] elapsed [2];
    logic                 moving [2];
    logic                 first_phase [2];
    servo_word_t          expected_words [$];
    int unsigned          mismatches;

    function new();
        first_press_ms = FIRST_PRESS_RESET;
        hold_ms        = HOLD_RESET;
        settle_ms      = SETTLE_RESET;
        ccw_us         = CCW_RESET;
        cw_us          = CW_RESET;
        for (int m = 0; m < 2; m++) begin
            pulse_us[m]    = NEUTRAL_PULSE;
            elapsed[m]     = '0;
            moving[m]      = 1'b0;
            first_phase[m] = 1'b1;
        end
        mismatches = 0;
    endfunction

    function void set_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] value);
        case (addr)
            CFG_FIRST_PRESS: first_press_ms = value;
            CFG_HOLD:        hold_ms = value;
            CFG_SETTLE:      settle_ms = value;
            default:         ;
        endcase
    endfunction

    function int clamp(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function void drive(int m, logic [PULSE_W-1:0] width);
        pulse_us[m] = width;
        elapsed[m]  = '0;
        moving[m]   = 1'b1;
    endfunction

    // Advances the predicted controller by one accepted word and queues the
    // result word that the block must produce for it.
    function void note_word(logic tick, logic [KEY_W-1:0] key);
        servo_word_t w;
        logic [CFG_W-1:0] limit;
        if (tick) begin
            for (int m = 0; m < 2; m++)
                if (moving[m] && elapsed[m] < ELAPSED_MAX)
                    elapsed[m] = elapsed[m] + 1'b1;
        end else begin
            case (key)
                KEY_Q_LO, KEY_Q_UP: begin
                    ccw_us = PULSE_W'(clamp(int'(ccw_us) + 100, CCW_MIN, CCW_MAX));
                    cw_us  = PULSE_W'(clamp(int'(cw_us) - 100, CW_MIN, CW_MAX));
                end
                KEY_E_LO, KEY_E_UP: begin
                    ccw_us = PULSE_W'(clamp(int'(ccw_us) - 100, CCW_MIN, CCW_MAX));
                    cw_us  = PULSE_W'(clamp(int'(cw_us) + 100, CW_MIN, CW_MAX));
                end
                KEY_A_LO, KEY_A_UP: drive(0, ccw_us);
                KEY_D_LO, KEY_D_UP: drive(0, cw_us);
                KEY_W_LO, KEY_W_UP: drive(1, ccw_us);
                KEY_S_LO, KEY_S_UP: drive(1, cw_us);
                default: ;
            endcase
        end
        // The limit is picked from the phase flag as it stood before the check.
        for (int m = 0; m < 2; m++) begin
            if (moving[m]) begin
                limit = first_phase[m] ? first_press_ms : hold_ms;
                if (elapsed[m] > limit) begin
                    pulse_us[m]    = NEUTRAL_PULSE;
                    moving[m]      = 1'b0;
                    first_phase[m] = 1'b1;
                end else if (elapsed[m] > settle_ms) begin
                    first_phase[m] = 1'b0;
                end
            end
        end
        w                  = '0;
        w.motor_one_pulse  = pulse_us[0];
        w.motor_two_pulse  = pulse_us[1];
        w.motor_one_active = moving[0];
        w.motor_two_active = moving[1];
        w.ccw_width        = ccw_us;
        w.cw_width         = cw_us;
        expected_words.push_back(w);
    endfunction

    function void compare_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    function void check_word(logic [RESULT_W-1:0] data);
        servo_word_t got;
        servo_word_t exp_w;
        got = data;
        if (expected_words.size() == 0) begin
            $error("result word: expected none, got %h", data);
            mismatches++;
            return;
        end
        exp_w = expected_words.pop_front();
        compare_field("motor_one_pulse", exp_w.motor_one_pulse, got.motor_one_pulse);
        compare_field("motor_two_pulse", exp_w.motor_two_pulse, got.motor_two_pulse);
        compare_field("motor_one_active", exp_w.motor_one_active, got.motor_one_active);
        compare_field("motor_two_active", exp_w.motor_two_active, got.motor_two_active);
        compare_field("ccw_width", exp_w.ccw_width, got.ccw_width);
        compare_field("cw_width", exp_w.cw_width, got.cw_width);
    endfunction

    function int pending();
        return expected_words.size();
    endfunction
endclass

module tb_dual_servo_jog_with_release_timeout;

    // Quiet cycles (nothing accepted on either side) before the run is abandoned.
    // The worst legitimate gap is a long stall of the receiver, so this leaves a
    // wide margin.
    localparam int unsigned QUIET_LIMIT = 2000;
    // Index 3 decodes to no register; a write there must leave all timing alone.
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_CR = 8'h0D;
    localparam logic [KEY_W-1:0] KEY_LF = 8'h0A;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [KEY_W-1:0]      s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [RESULT_W-1:0]   m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    jog_scoreboard sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles = 0;

    always #2 aclk = ~aclk;

    dual_servo_jog_with_release_timeout u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // The receiver decides afresh on every falling edge whether to stall.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result words are checked at the rising edge at which they are taken.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_word(m_tdata);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        $display("tb_dual_servo_jog_with_release_timeout: done, errors");
        $finish;
    end

    // Presents one word, starting and ending at a falling edge. The sender may
    // idle first; s_tvalid is only ever set once per time step.
    task automatic send_word(input logic tick, input logic [KEY_W-1:0] key);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= tick;
        s_tdata  <= key;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_word(tick, key);
        @(negedge aclk);
    endtask

    task automatic send_key(input logic [KEY_W-1:0] key);
        send_word(1'b0, key);
    endtask

    // Ticks carry a random byte, which the block must ignore.
    task automatic send_tick();
        send_word(1'b1, KEY_W'($urandom_range(0, 255)));
    endtask

    // Stops the input and waits until every expected result has come back,
    // so that the block is idle and the timing registers may be changed.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0)
            @(negedge aclk);
    endtask

    // Writes all three timing registers back to back, and optionally pokes the
    // unused index as well. The enable is lowered once, after the last write.
    task automatic load_timing(input logic [CFG_W-1:0] first_press,
                               input logic [CFG_W-1:0] hold,
                               input logic [CFG_W-1:0] settle,
                               input bit               poke_unused);
        logic [CFG_ADDR_W-1:0] addrs [4];
        logic [CFG_W-1:0]      vals [4];
        int                    n;
        addrs = '{CFG_FIRST_PRESS, CFG_HOLD, CFG_SETTLE, CFG_UNUSED};
        vals  = '{first_press, hold, settle, CFG_W'($urandom_range(0, 511))};
        n     = poke_unused ? 4 : 3;
        for (int i = 0; i < n; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= addrs[i];
            cfg_wdata <= vals[i];
            @(negedge aclk);
            sb.set_register(addrs[i], vals[i]);
        end
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [KEY_W-1:0] pick_drive_key();
        case ($urandom_range(0, 7))
            0: return KEY_A_LO;
            1: return KEY_A_UP;
            2: return KEY_D_LO;
            3: return KEY_D_UP;
            4: return KEY_W_LO;
            5: return KEY_W_UP;
            6: return KEY_S_LO;
            default: return KEY_S_UP;
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] pick_speed_key();
        case ($urandom_range(0, 3))
            0: return KEY_Q_LO;
            1: return KEY_Q_UP;
            2: return KEY_E_LO;
            default: return KEY_E_UP;
        endcase
    endfunction

    // Random traffic. Most of it is a drive followed by a run of ticks long
    // enough to reach the settle window and the timeouts; the rest is speed
    // changes, arbitrary bytes and stray ticks.
    task automatic run_random(input int unsigned n_words);
        int unsigned sent;
        int unsigned span;
        int unsigned run_len;
        int unsigned pick;
        sent = 0;
        span = (sb.first_press_ms > sb.hold_ms) ? sb.first_press_ms : sb.hold_ms;
        if (span > 120)
            span = 120;
        span = span + 12;
        while (sent < n_words) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_key(pick_drive_key());
                sent++;
                run_len = $urandom_range(0, span);
                for (int i = 0; i < run_len; i++) begin
                    // Now and then a command lands in the middle of a run.
                    if ($urandom_range(0, 99) < 8)
                        send_key($urandom_range(0, 3) == 0 ? pick_drive_key()
                                                            : KEY_W'($urandom_range(0, 255)));
                    else
                        send_tick();
                    sent++;
                end
            end else if (pick < 70) begin
                send_key(pick_speed_key());
                sent++;
            end else if (pick < 85) begin
                send_key(KEY_W'($urandom_range(0, 255)));
                sent++;
            end else begin
                run_len = $urandom_range(1, 5);
                for (int i = 0; i < run_len; i++)
                    send_tick();
                sent += run_len;
            end
        end
    endtask

    // Idling alternates: sender light and receiver heavy, then the other way
    // round, then no idling at all.
    task automatic set_idling(input int unsigned phase);
        case (phase % 3)
            0: begin
                send_idle_pct  = 26;
                recv_stall_pct = 79;
            end
            1: begin
                send_idle_pct  = 79;
                recv_stall_pct = 26;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Phase 0: timing at its reset values.
        set_idling(0);
        send_tick();                // tick with no motor moving
        send_key(8'h00);            // lowest and highest bytes do nothing
        send_key(8'hFF);
        send_key(KEY_CR);           // line endings are ignored as well
        send_key(KEY_LF);
        send_key(KEY_Q_LO);         // both widths hit their inner limits at once
        send_key(KEY_Q_UP);
        send_key(KEY_E_LO);         // walk the widths out to their outer limits
        send_key(KEY_E_UP);
        send_key(KEY_E_LO);
        send_key(KEY_E_UP);
        send_key(KEY_E_LO);
        send_key(KEY_A_LO);         // every drive key, both cases
        send_key(KEY_D_UP);
        send_key(KEY_W_LO);
        send_key(KEY_S_UP);
        send_tick();
        send_key(KEY_A_UP);         // redrive while moving keeps the phase flag
        send_key(KEY_D_LO);
        send_key(KEY_W_UP);
        send_key(KEY_S_LO);
        send_tick();
        run_random(240);

        // Phase 1: zero timeouts, so a driven motor stops at its first tick.
        wait_for_drain();
        load_timing(9'd0, 9'd0, 9'd0, 1'b0);
        set_idling(1);
        run_random(250);

        // Phase 2: all at the top. The elapsed count saturates and never
        // passes a timeout of 511, so both motors keep running.
        wait_for_drain();
        load_timing(9'd511, 9'd511, 9'd511, 1'b0);
        set_idling(2);
        send_key(KEY_A_LO);
        send_key(KEY_S_LO);
        for (int i = 0; i < 520; i++)
            send_tick();
        run_random(60);

        // Phase 3: short random timings, so timeouts are frequent.
        wait_for_drain();
        load_timing(CFG_W'($urandom_range(1, 40)), CFG_W'($urandom_range(1, 40)),
                    CFG_W'($urandom_range(0, 40)), 1'b0);
        set_idling(3);
        run_random(240);

        // Phase 4: a settle window longer than both timeouts, so the motor
        // never leaves its first-press phase.
        wait_for_drain();
        load_timing(CFG_W'($urandom_range(5, 30)), CFG_W'($urandom_range(0, 10)),
                    CFG_W'($urandom_range(200, 511)), 1'b0);
        set_idling(4);
        run_random(250);

        // Phase 5: random timing, with a stray write to the unused index that
        // must change nothing.
        wait_for_drain();
        load_timing(CFG_W'($urandom_range(0, 60)), CFG_W'($urandom_range(0, 60)),
                    CFG_W'($urandom_range(0, 60)), 1'b1);
        set_idling(5);
        run_random(250);

        wait_for_drain();
        // Keep the clock running so that any surplus result would show.
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_dual_servo_jog_with_release_timeout: done, clean");
        else
            $display("tb_dual_servo_jog_with_release_timeout: done, errors");
        $finish;
    end

endmodule
